// File: hdl/jcrs_pkg.sv
// Shared types and constants for the joint command ramp smoother.
// Used by the top level of the smoother; depends on nothing else.
package jcrs_pkg;

  // Number of joints per item and the width of the ramp length register.
  localparam int unsigned JOINTS = 6;
  localparam int unsigned TICK_W = 10;
  localparam int unsigned JNT_W  = (JOINTS > 1) ? $clog2(JOINTS) : 1;

  // Item opcodes.
  localparam logic OP_STEP = 1'b0;
  localparam logic OP_HOLD = 1'b1;

  // Sequencer states of the top level.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_CALC,
    ST_LOAD,
    ST_MUL,
    ST_DIV,
    ST_EMIT
  } state_e;

endpackage

// File: hdl/jcrs_mul.sv
// Bit-serial shift-and-add multiplier: one multiplier bit per cycle.
// Depends on nothing; instantiated by the ramp smoother top level.
module jcrs_mul #(
  parameter int unsigned AW = 16,
  parameter int unsigned BW = 10
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [AW-1:0]   a_i,
  input  logic [BW-1:0]   b_i,
  output logic            done_o,
  output logic [AW+BW-1:0] prod_o
);

  localparam int unsigned PW = AW + BW;
  localparam int unsigned CW = $clog2(BW + 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [PW-1:0] acc_q, acc_d;
  logic [PW-1:0] mcand_q, mcand_d;
  logic [BW-1:0] mplier_q, mplier_d;

  // One partial product is added per cycle while busy.
  always_comb begin
    busy_d   = busy_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    if (start_i) begin
      busy_d   = 1'b1;
      cnt_d    = CW'(BW);
      acc_d    = '0;
      mcand_d  = PW'(a_i);
      mplier_d = b_i;
    end else if (busy_q) begin
      if (mplier_q[0]) begin
        acc_d = acc_q + mcand_q;
      end
      mcand_d  = {mcand_q[PW-2:0], 1'b0};
      mplier_d = {1'b0, mplier_q[BW-1:1]};
      cnt_d    = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Shift registers of the datapath.
  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// File: hdl/jcrs_div.sv
// Restoring divider that produces one quotient bit per cycle.
// Depends on nothing; instantiated by the ramp smoother top level.
module jcrs_div #(
  parameter int unsigned QW = 16,
  parameter int unsigned DW = 11
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [QW+DW-1:0]   num_i,
  input  logic [DW-1:0]      den_i,
  output logic               done_o,
  output logic [QW-1:0]      quo_o
);

  localparam int unsigned NW = QW + DW;
  localparam int unsigned CW = $clog2(QW + 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [QW-1:0] sh_q, sh_d;
  logic [DW-1:0] den_q, den_d;
  logic [DW:0]   trial;
  logic          ge;

  // The upper numerator bits already lie below the divisor, because the
  // quotient fits in QW bits, so only the low QW bits are shifted through.
  always_comb begin
    trial  = {rem_q, sh_q[QW-1]};
    ge     = (trial >= {1'b0, den_q});
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    sh_d   = sh_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(QW);
      rem_d  = num_i[NW-1:QW];
      sh_d   = num_i[QW-1:0];
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d = ge ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
      sh_d  = {sh_q[QW-2:0], ge};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Remainder, numerator/quotient shift register and divisor.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q  <= sh_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = sh_q;

endmodule

// File: hdl/joint_command_ramp_smoother_unit.sv
// Top level of the joint command ramp smoother: ramp state, sequencer, output register.
// Depends on jcrs_pkg, jcrs_mul and jcrs_div.
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+--------------------------------------
//   input    | in_valid_i / in_stall_o     | opcode_i, joint_0_i .. joint_5_i
//   result   | out_valid_o / out_stall_i   | smooth_0_o .. smooth_5_o,
//            |                             | ramp_active_o, hold_flag_o
//   config   | cfg_we_i                    | cfg_wdata_i (smoothing ticks)
//
// A hold item passes through the prepare state and emits no result. A step item
// with ticks of 0 or 1 goes from the calculate state straight to the emit state;
// otherwise each joint goes through the serial multiplier and the serial divider
// in turn before the result is emitted.
// Reset clears the counter, the flags and the ramp length; the ramp vectors
// are loaded by the first item after reset.
// A finished result waits in the output register while the next item is
// taken in; that item stalls only when its own result would overwrite it.
module joint_command_ramp_smoother_unit #(
  parameter int unsigned POS_WIDTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [jcrs_pkg::TICK_W-1:0]          cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 opcode_i,
  input  logic signed [POS_WIDTH-1:0]          joint_0_i,
  input  logic signed [POS_WIDTH-1:0]          joint_1_i,
  input  logic signed [POS_WIDTH-1:0]          joint_2_i,
  input  logic signed [POS_WIDTH-1:0]          joint_3_i,
  input  logic signed [POS_WIDTH-1:0]          joint_4_i,
  input  logic signed [POS_WIDTH-1:0]          joint_5_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [POS_WIDTH-1:0]          smooth_0_o,
  output logic signed [POS_WIDTH-1:0]          smooth_1_o,
  output logic signed [POS_WIDTH-1:0]          smooth_2_o,
  output logic signed [POS_WIDTH-1:0]          smooth_3_o,
  output logic signed [POS_WIDTH-1:0]          smooth_4_o,
  output logic signed [POS_WIDTH-1:0]          smooth_5_o,
  output logic                                 ramp_active_o,
  output logic                                 hold_flag_o
);

  import jcrs_pkg::*;

  localparam int unsigned PRODW = POS_WIDTH + TICK_W;
  localparam int unsigned DENW  = TICK_W + 1;
  localparam int unsigned NUMW  = POS_WIDTH + DENW;

  state_e state_q, state_d;

  logic [TICK_W-1:0]           ticks_q;
  logic [TICK_W-1:0]           cnt_q;
  logic [TICK_W-1:0]           c_q;
  logic                        primed_q;
  logic                        hold_q;
  logic                        op_q;
  logic [JNT_W-1:0]            jnt_q;
  logic                        neg_q;
  logic                        out_valid_q;

  logic signed [POS_WIDTH-1:0] din_q    [JOINTS];
  logic signed [POS_WIDTH-1:0] start_q  [JOINTS];
  logic signed [POS_WIDTH-1:0] target_q [JOINTS];
  logic signed [POS_WIDTH-1:0] smooth_q [JOINTS];
  logic signed [POS_WIDTH-1:0] res_q    [JOINTS];
  logic                        ract_q;
  logic                        hflag_q;

  logic signed [POS_WIDTH-1:0] din_w    [JOINTS];
  logic                        accept;
  logic                        differ;
  logic                        no_smooth;
  logic [TICK_W:0]             cnt_inc;
  logic [TICK_W-1:0]           c_next;
  logic [POS_WIDTH:0]          diff;
  logic [POS_WIDTH:0]          diff_abs;
  logic [POS_WIDTH-1:0]        mag;
  logic                        last_jnt;
  logic                        mul_start;
  logic                        mul_done;
  logic [PRODW-1:0]            prod;
  logic                        div_start;
  logic                        div_done;
  logic [NUMW-1:0]             num;
  logic [DENW-1:0]             den;
  logic [POS_WIDTH-1:0]        quo;
  logic                        emit;

  // Gather the joint ports into one array.
  assign din_w[0] = joint_0_i;
  assign din_w[1] = joint_1_i;
  assign din_w[2] = joint_2_i;
  assign din_w[3] = joint_3_i;
  assign din_w[4] = joint_4_i;
  assign din_w[5] = joint_5_i;

  // A new desired vector restarts the ramp when any joint differs from the target.
  always_comb begin
    differ = 1'b0;
    for (int i = 0; i < JOINTS; i++) begin
      if (din_q[i] != target_q[i]) begin
        differ = 1'b1;
      end
    end
  end

  // Ramp position for this step, saturated at the ramp length.
  assign no_smooth = (ticks_q <= TICK_W'(1));
  assign cnt_inc   = {1'b0, cnt_q} + (TICK_W + 1)'(1);
  assign c_next    = (cnt_inc > {1'b0, ticks_q}) ? ticks_q : cnt_inc[TICK_W-1:0];

  // Magnitude and sign of target minus start for the current joint.
  assign diff     = {target_q[jnt_q][POS_WIDTH-1], target_q[jnt_q]}
                  - {start_q[jnt_q][POS_WIDTH-1], start_q[jnt_q]};
  assign diff_abs = diff[POS_WIDTH] ? (POS_WIDTH + 1)'(-diff) : diff;
  assign mag      = diff_abs[POS_WIDTH-1:0];
  assign last_jnt = (jnt_q == JNT_W'(JOINTS - 1));

  // Rounded quotient: (2 * mag * c + ticks) / (2 * ticks).
  assign num = {prod, 1'b0} + NUMW'(ticks_q);
  assign den = {ticks_q, 1'b0};

  jcrs_mul #(
    .AW (POS_WIDTH),
    .BW (TICK_W)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mag),
    .b_i     (c_q),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  jcrs_div #(
    .QW (POS_WIDTH),
    .DW (DENW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num),
    .den_i   (den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        state_d = (op_q == OP_HOLD) ? ST_IDLE : ST_CALC;
      end
      ST_CALC: begin
        state_d = no_smooth ? ST_EMIT : ST_LOAD;
      end
      ST_LOAD: begin
        state_d = ST_MUL;
      end
      ST_MUL: begin
        if (mul_done) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = last_jnt ? ST_EMIT : ST_LOAD;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall_o = 1'b1;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    emit       = 1'b0;
    case (state_q)
      ST_IDLE: in_stall_o = 1'b0;
      ST_LOAD: mul_start  = 1'b1;
      ST_MUL:  div_start  = mul_done;
      ST_EMIT: emit       = !out_valid_q || !out_stall_i;
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  assign accept = in_valid_i && !in_stall_o;

  // Control state: sequencer, configuration, counters and flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ticks_q     <= '0;
      cnt_q       <= '0;
      primed_q    <= 1'b0;
      hold_q      <= 1'b0;
      jnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        ticks_q <= cfg_wdata_i;
      end
      case (state_q)
        ST_PREP: begin
          if (op_q == OP_HOLD) begin
            hold_q <= 1'b1;
          end
          if (!primed_q) begin
            primed_q <= 1'b1;
            cnt_q    <= ticks_q;
          end else if ((op_q == OP_HOLD) || differ) begin
            cnt_q <= '0;
          end
        end
        ST_CALC: begin
          jnt_q <= '0;
          if (!no_smooth && (cnt_q < ticks_q)) begin
            cnt_q <= cnt_q + TICK_W'(1);
          end
        end
        ST_DIV: begin
          if (div_done && !last_jnt) begin
            jnt_q <= jnt_q + JNT_W'(1);
          end
        end
        default: begin
          jnt_q <= jnt_q;
        end
      endcase
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Ramp vectors, captured item and the output register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= opcode_i;
      for (int i = 0; i < JOINTS; i++) begin
        din_q[i] <= din_w[i];
      end
    end
    case (state_q)
      ST_PREP: begin
        // The first item snaps everything; later hold items or new targets retarget from the smoothed value.
        if (!primed_q) begin
          for (int i = 0; i < JOINTS; i++) begin
            start_q[i]  <= din_q[i];
            target_q[i] <= din_q[i];
            smooth_q[i] <= din_q[i];
          end
        end else if ((op_q == OP_HOLD) || differ) begin
          for (int i = 0; i < JOINTS; i++) begin
            start_q[i]  <= smooth_q[i];
            target_q[i] <= din_q[i];
          end
        end
      end
      ST_CALC: begin
        c_q <= c_next;
        if (no_smooth) begin
          for (int i = 0; i < JOINTS; i++) begin
            smooth_q[i] <= target_q[i];
          end
        end
      end
      ST_LOAD: begin
        neg_q <= diff[POS_WIDTH];
      end
      ST_DIV: begin
        if (div_done) begin
          smooth_q[jnt_q] <= neg_q ? start_q[jnt_q] - $signed(quo)
                                   : start_q[jnt_q] + $signed(quo);
        end
      end
      default: begin
        c_q <= c_q;
      end
    endcase
    if (emit) begin
      for (int i = 0; i < JOINTS; i++) begin
        res_q[i] <= smooth_q[i];
      end
      ract_q  <= (cnt_q < ticks_q);
      hflag_q <= hold_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign smooth_0_o    = res_q[0];
  assign smooth_1_o    = res_q[1];
  assign smooth_2_o    = res_q[2];
  assign smooth_3_o    = res_q[3];
  assign smooth_4_o    = res_q[4];
  assign smooth_5_o    = res_q[5];
  assign ramp_active_o = ract_q;
  assign hold_flag_o   = hflag_q;

  // A result appears only after the sequencer reaches its emit state.
  a_rise_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_EMIT))
    else $error("result raised outside the emit state");

  // The multiplier finishes only while the sequencer waits for it.
  a_mul_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == ST_MUL))
    else $error("multiplier finished outside its wait state");

  // The divider finishes only while the sequencer waits for it.
  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider finished outside its wait state");

  // The joint index stays within the vector while a joint is worked on.
  a_jnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD) |-> (jnt_q <= JNT_W'(JOINTS - 1)))
    else $error("joint index out of range");

  // Emitting over a result that is still stalled must never happen.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && out_valid_q) |-> !out_stall_i)
    else $error("stalled result overwritten");

endmodule
